// ===== design/trci_pkg.sv =====
package trci_pkg;

    // Geometry and arithmetic widths.
    localparam int COORD_BITS = 12;
    localparam int VERT_W     = 24 + 2 * COORD_BITS;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int EDGE_W     = PROD_W + 1;
    localparam int CPROD_W    = EDGE_W + 9;
    localparam int NUM_W      = CPROD_W + 2;
    localparam int SIZE_W     = 13;
    localparam int PIX_W      = 12;
    localparam int SCR_W      = SIZE_W + 2;
    localparam int COLOR_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [COLOR_W-1:0] COLOR_MAX = 8'd255;
    localparam logic [2:0]         DIV_LAST  = 3'd7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd4;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic [VERT_W-1:0] va;
        logic [VERT_W-1:0] vb;
        logic [VERT_W-1:0] vc;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } t_cfg;

    // One point command from the walker to the shading engine.
    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
        logic   degen;
    } t_cmd;

    function automatic t_coord vert_x(input logic [VERT_W-1:0] v);
        vert_x = t_coord'(v[VERT_W-1 -: COORD_BITS]);
    endfunction

    function automatic t_coord vert_y(input logic [VERT_W-1:0] v);
        vert_y = t_coord'(v[24 +: COORD_BITS]);
    endfunction

    function automatic logic [COLOR_W-1:0] chan(input logic [VERT_W-1:0] v,
                                                 input logic [1:0] k);
        chan = v[(2 - k) * COLOR_W +: COLOR_W];
    endfunction

    function automatic logic signed [DIFF_W-1:0] cdiff(input t_coord a, input t_coord b);
        cdiff = DIFF_W'(a) - DIFF_W'(b);
    endfunction

endpackage

// ===== design/trci_front.sv =====
module trci_front import trci_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_valid,
    output logic o_ready,
    input  logic i_restart,
    input  logic i_full,
    output logic o_push,
    output t_cmd o_cmd
);

    t_coord ax, ay, bx, by, cx, cy;
    t_coord minx, maxx, miny, maxy;
    t_coord nx, ny;
    t_coord r_walk_x, r_walk_y;
    logic   r_active;
    logic signed [PROD_W-1:0] p0, p1;
    logic signed [EDGE_W-1:0] area;
    logic   degen, last, accept;

    // Bounding box and signed doubled area of the current triangle.
    always_comb begin
        ax = vert_x(i_cfg.va);
        ay = vert_y(i_cfg.va);
        bx = vert_x(i_cfg.vb);
        by = vert_y(i_cfg.vb);
        cx = vert_x(i_cfg.vc);
        cy = vert_y(i_cfg.vc);
        minx = (ax < bx) ? ax : bx;
        minx = (minx < cx) ? minx : cx;
        maxx = (ax > bx) ? ax : bx;
        maxx = (maxx > cx) ? maxx : cx;
        miny = (ay < by) ? ay : by;
        miny = (miny < cy) ? miny : cy;
        maxy = (ay > by) ? ay : by;
        maxy = (maxy > cy) ? maxy : cy;
        p0 = cdiff(bx, ax) * cdiff(cy, ay);
        p1 = cdiff(cx, ax) * cdiff(by, ay);
        area = EDGE_W'(p0) - EDGE_W'(p1);
        degen = (area == '0);
    end

    // Next walk point: y inner, x outer.
    always_comb begin
        if (i_restart) begin
            nx = minx;
            ny = miny;
        end else if (r_walk_y < maxy) begin
            nx = r_walk_x;
            ny = r_walk_y + t_coord'(1);
        end else begin
            nx = r_walk_x + t_coord'(1);
            ny = miny;
        end
        last = (nx >= maxx) && (ny >= maxy);
    end

    // An advance with no walk active produces nothing, even for a zero-area triangle.
    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept && (i_restart || r_active);

    always_comb begin
        o_cmd.x     = degen ? t_coord'(0) : nx;
        o_cmd.y     = degen ? t_coord'(0) : ny;
        o_cmd.last  = degen || last;
        o_cmd.degen = degen;
    end

    // Walk state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk_x <= '0;
            r_walk_y <= '0;
            r_active <= 1'b0;
        end else if (o_push) begin
            if (degen) begin
                r_active <= 1'b0;
            end else begin
                r_walk_x <= nx;
                r_walk_y <= ny;
                r_active <= !last;
            end
        end
    end

endmodule

// ===== design/trci_queue.sv =====
module trci_queue import trci_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd       r_mem [0:1];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    // Two-entry command queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== design/trci_back.sv =====
module trci_back import trci_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_empty,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [PIX_W-1:0]   o_pixel_x,
    output logic [PIX_W-1:0]   o_pixel_y,
    output logic [COLOR_W-1:0] o_red,
    output logic [COLOR_W-1:0] o_green,
    output logic [COLOR_W-1:0] o_blue,
    output logic               o_write_pixel,
    output logic               o_degenerate,
    output logic               o_last
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PROD  = 3'd1;
    localparam logic [2:0] ST_EDGE  = 3'd2;
    localparam logic [2:0] ST_COLOR = 3'd3;
    localparam logic [2:0] ST_SUM   = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] r_cnt;
    t_coord     r_x, r_y;
    logic       r_last, r_degen, r_wr;

    logic signed [PROD_W-1:0]  r_prod [0:7];
    logic signed [PROD_W-1:0]  p [0:7];
    logic signed [EDGE_W-1:0]  r_d [0:2];
    logic signed [EDGE_W-1:0]  r_area;
    logic [NUM_W-1:0]          r_aabs;
    logic signed [CPROD_W-1:0] r_cp [0:2][0:2];
    logic [NUM_W-1:0]          r_rem [0:2];
    logic [NUM_W-1:0]          r_den_sh;
    logic [COLOR_W-1:0]        r_q [0:2];
    logic                      r_sat [0:2];
    logic                      r_zero [0:2];
    logic [PIX_W-1:0]          r_px, r_py;

    t_coord ax, ay, bx, by, cx, cy;
    logic signed [SCR_W-1:0] xb, yb, w_s, h_s;
    logic neg, pos, onscr;
    logic signed [NUM_W-1:0] n [0:2];
    logic [NUM_W-1:0] n_abs [0:2];
    logic [NUM_W-1:0] area_ext;
    logic [COLOR_W-1:0] col [0:2];

    always_comb begin
        ax = vert_x(i_cfg.va);
        ay = vert_y(i_cfg.va);
        bx = vert_x(i_cfg.vb);
        by = vert_y(i_cfg.vb);
        cx = vert_x(i_cfg.vc);
        cy = vert_y(i_cfg.vc);
    end

    // Edge function and area partial products, one multiplier each.
    always_comb begin
        p[0] = cdiff(r_x, bx) * cdiff(ay, by);
        p[1] = cdiff(ax, bx) * cdiff(r_y, by);
        p[2] = cdiff(r_x, cx) * cdiff(by, cy);
        p[3] = cdiff(bx, cx) * cdiff(r_y, cy);
        p[4] = cdiff(r_x, ax) * cdiff(cy, ay);
        p[5] = cdiff(cx, ax) * cdiff(r_y, ay);
        p[6] = cdiff(bx, ax) * cdiff(cy, ay);
        p[7] = cdiff(cx, ax) * cdiff(by, ay);
    end

    // Inside test and screen mapping.
    always_comb begin
        neg = r_d[0] < 0 || r_d[1] < 0 || r_d[2] < 0;
        pos = r_d[0] > 0 || r_d[1] > 0 || r_d[2] > 0;
        w_s = $signed(SCR_W'(i_cfg.width));
        h_s = $signed(SCR_W'(i_cfg.height));
        xb  = SCR_W'(r_x) + $signed(SCR_W'(i_cfg.width[SIZE_W-1:1]));
        yb  = $signed(SCR_W'(i_cfg.height[SIZE_W-1:1])) - SCR_W'(r_y) - SCR_W'(1);
        onscr = (xb >= 0) && (xb < w_s) && (yb >= 0) && (yb < h_s);
        area_ext = NUM_W'(r_area);
    end

    // Numerator sums, their magnitudes and the output colors.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n[k] = NUM_W'(r_cp[k][0]) + NUM_W'(r_cp[k][1]) + NUM_W'(r_cp[k][2]);
            n_abs[k] = n[k][NUM_W-1] ? NUM_W'(-n[k]) : NUM_W'(n[k]);
            col[k] = (!r_wr || r_zero[k]) ? '0 : (r_sat[k] ? COLOR_MAX : r_q[k]);
        end
    end

    assign o_pop = (r_state == ST_IDLE) && !i_empty;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            o_valid <= 1'b0;
        end else begin
            // The result register empties unless a new result is loaded this cycle.
            if (o_valid && i_ready && (r_state != ST_DONE)) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_state <= i_cmd.degen ? ST_DONE : ST_PROD;
                    end
                end
                ST_PROD:  r_state <= ST_EDGE;
                ST_EDGE:  r_state <= ST_COLOR;
                ST_COLOR: r_state <= ST_SUM;
                ST_SUM: begin
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!o_valid || i_ready) begin
                        o_valid <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_x     <= i_cmd.x;
                r_y     <= i_cmd.y;
                r_last  <= i_cmd.last;
                r_degen <= i_cmd.degen;
                r_wr    <= 1'b0;
            end
            ST_PROD: begin
                for (int i = 0; i < 8; i++) begin
                    r_prod[i] <= p[i];
                end
            end
            ST_EDGE: begin
                r_d[0] <= EDGE_W'(r_prod[0]) - EDGE_W'(r_prod[1]);
                r_d[1] <= EDGE_W'(r_prod[2]) - EDGE_W'(r_prod[3]);
                r_d[2] <= EDGE_W'(r_prod[4]) - EDGE_W'(r_prod[5]);
                r_area <= EDGE_W'(r_prod[6]) - EDGE_W'(r_prod[7]);
            end
            ST_COLOR: begin
                r_wr   <= !(neg && pos) && onscr;
                r_px   <= xb[PIX_W-1:0];
                r_py   <= yb[PIX_W-1:0];
                r_aabs <= r_area[EDGE_W-1] ? NUM_W'(-$signed(area_ext)) : area_ext;
                for (int k = 0; k < 3; k++) begin
                    r_cp[k][0] <= r_d[1] * $signed({1'b0, chan(i_cfg.va, 2'(k))});
                    r_cp[k][1] <= r_d[2] * $signed({1'b0, chan(i_cfg.vb, 2'(k))});
                    r_cp[k][2] <= r_d[0] * $signed({1'b0, chan(i_cfg.vc, 2'(k))});
                end
            end
            ST_SUM: begin
                r_den_sh <= {r_aabs[NUM_W-8:0], 7'b0};
                for (int k = 0; k < 3; k++) begin
                    r_rem[k]  <= n_abs[k];
                    r_q[k]    <= '0;
                    r_zero[k] <= (n[k] == '0) || (n[k][NUM_W-1] != r_area[EDGE_W-1]);
                    r_sat[k]  <= n_abs[k] >= {r_aabs[NUM_W-9:0], 8'b0};
                end
            end
            ST_DIV: begin
                // One restoring quotient bit per cycle for each channel.
                r_den_sh <= r_den_sh >> 1;
                for (int k = 0; k < 3; k++) begin
                    if (r_rem[k] >= r_den_sh) begin
                        r_rem[k] <= r_rem[k] - r_den_sh;
                        r_q[k]   <= {r_q[k][COLOR_W-2:0], 1'b1};
                    end else begin
                        r_q[k]   <= {r_q[k][COLOR_W-2:0], 1'b0};
                    end
                end
            end
            ST_DONE: begin
                if (!o_valid || i_ready) begin
                    o_pixel_x     <= r_wr ? r_px : '0;
                    o_pixel_y     <= r_wr ? r_py : '0;
                    o_red         <= col[0];
                    o_green       <= col[1];
                    o_blue        <= col[2];
                    o_write_pixel <= r_wr;
                    o_degenerate  <= r_degen;
                    o_last        <= r_last;
                end
            end
            default: begin
                r_wr <= 1'b0;
            end
        endcase
    end

endmodule

// ===== design/triangle_raster_color_interp.sv =====
// Triangle rasterizer with barycentric color shading. Write the three vertices
// and the frame size on the configuration port while the block is idle, then
// send a transaction with restart=1 to visit the bounding box corner and one
// with restart=0 for each further point (y inner, x outer). Each visit yields
// one result; last marks the final point, and a zero-area triangle yields a
// single result with degenerate and last set. An advance with no walk active
// yields nothing. The walker takes a transaction every cycle while its
// two-entry command queue has room; the shading engine handles one point at a
// time through its 8-step color divider and takes the next only after loading
// the last result into the output register.
module triangle_raster_color_interp import trci_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_restart,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PIX_W-1:0]      o_pixel_x,
    output logic [PIX_W-1:0]      o_pixel_y,
    output logic [COLOR_W-1:0]    o_red,
    output logic [COLOR_W-1:0]    o_green,
    output logic [COLOR_W-1:0]    o_blue,
    output logic                  o_write_pixel,
    output logic                  o_degenerate,
    output logic                  o_last
);

    t_cfg r_cfg;
    t_cmd push_cmd, pop_cmd;
    logic push, pop, full, empty;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.va     <= '0;
            r_cfg.vb     <= '0;
            r_cfg.vc     <= '0;
            r_cfg.width  <= SIZE_W'(1024);
            r_cfg.height <= SIZE_W'(1024);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_VERTEX_A: r_cfg.va     <= i_cfg_data[VERT_W-1:0];
                CFG_VERTEX_B: r_cfg.vb     <= i_cfg_data[VERT_W-1:0];
                CFG_VERTEX_C: r_cfg.vc     <= i_cfg_data[VERT_W-1:0];
                CFG_WIDTH:    r_cfg.width  <= i_cfg_data[SIZE_W-1:0];
                CFG_HEIGHT:   r_cfg.height <= i_cfg_data[SIZE_W-1:0];
                default:      r_cfg.width  <= r_cfg.width;
            endcase
        end
    end

    trci_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_restart (i_restart),
        .i_full    (full),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    trci_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (pop_cmd)
    );

    trci_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_empty       (empty),
        .i_cmd         (pop_cmd),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_write_pixel (o_write_pixel),
        .o_degenerate  (o_degenerate),
        .o_last        (o_last)
    );

    // A degenerate result closes the walk and never writes.
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_last && !o_write_pixel)
        else $error("degenerate result without last or with a write");

    // Unwritten results carry zero coordinates and color.
    a_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_write_pixel |-> o_pixel_x == '0 && o_pixel_y == '0 &&
            o_red == '0 && o_green == '0 && o_blue == '0)
        else $error("unwritten result carries nonzero fields");

    // The queue never pops empty and never accepts while full.
    a_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && empty) && !(push && full))
        else $error("command queue overflow or underflow");

endmodule
